FILE: rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

    // Field widths of a request and a response.
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    // Default number of slots in the table.
    localparam int DEF_CAPACITY = 16;

    // Request command codes. The fourth code is unused and reports not found.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;

    // Response status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ERASED   = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // clear one valid bit per cycle after reset
        logic start;   // capture a new request and restart the scan
        logic scan;    // issue slot reads
        logic finish;  // write back and load the response register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;  // last slot is being cleared this cycle
        logic scan_done;   // key found or every slot checked
        logic out_free;    // response register can take a new response
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/kvt_if.sv
`default_nettype none

// Request channel: command, key and value.
interface kvt_req_if;
    import kvt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic        [CMD_W-1:0] command;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output command, output lookup_key, output new_value,
                    input ready);
    modport sink   (input valid, input command, input lookup_key, input new_value,
                    output ready);
endinterface

// Response channel: status, value on a find hit, entry count and empty flag.
interface kvt_rsp_if;
    import kvt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [STAT_W-1:0]  status;
    logic signed [VAL_W-1:0]   found_value;
    logic        [COUNT_W-1:0] entry_count;
    logic                      is_empty;

    modport source (output valid, output status, output found_value, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input found_value, input entry_count,
                    input is_empty, output ready);
endinterface

`default_nettype wire

FILE: rtl/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire kvt_pkg::t_dp_stat  i_stat,
    output kvt_pkg::t_dp_cmd        o_cmd
);
    import kvt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A request is taken only between commands, after the clearing pass.
    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = o_req_ready && i_req_valid;

    // Commands to the datapath follow the state directly.
    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.start  = accept;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH) && i_stat.out_free;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // The scan never starts before the valid bits are cleared.
    a_no_scan_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !$past(accept))
        else $error("request accepted during clearing pass");

    // A response is loaded only after a scan has completed.
    a_finish_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !o_req_ready && !o_cmd.scan)
        else $error("finish issued outside the finish state");

    // A started command moves straight into the scan.
    a_start_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

endmodule

`default_nettype wire

FILE: rtl/kvt_dpath.sv
`default_nettype none

module kvt_dpath #(
    parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire kvt_pkg::t_dp_cmd               i_cmd,
    output kvt_pkg::t_dp_stat                   o_stat,
    input  wire logic        [kvt_pkg::CMD_W-1:0]   i_req_command,
    input  wire logic signed [kvt_pkg::KEY_W-1:0]   i_req_key,
    input  wire logic signed [kvt_pkg::VAL_W-1:0]   i_req_value,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic             [kvt_pkg::STAT_W-1:0]  o_status,
    output logic signed      [kvt_pkg::VAL_W-1:0]   o_found_value,
    output logic             [kvt_pkg::COUNT_W-1:0] o_entry_count,
    output logic                                o_is_empty
);
    import kvt_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);

    // Slot storage: one write port and one registered read port each.
    logic [KEY_W-1:0] mem_key [CAPACITY];
    logic [VAL_W-1:0] mem_val [CAPACITY];
    logic             mem_vld [CAPACITY];

    // Captured request.
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // Scan pipeline.
    logic [CNTW-1:0]  r_issue_cnt;
    logic             r_chk_vld;
    logic [IW-1:0]    r_chk_idx;
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;
    logic             r_rd_vld;
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_free;
    logic [IW-1:0]    r_free_idx;
    logic             r_chk_done;

    // Clearing pass and entry count.
    logic [IW-1:0]    r_clr_addr;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  n_count;

    // Response register.
    logic               r_out_vld;
    t_status            r_out_status;
    logic [VAL_W-1:0]   r_out_value;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_empty;

    logic                issue_en;
    logic [IW-1:0]       issue_addr;
    t_status             n_status;
    logic [VAL_W-1:0]    n_value;
    logic [CNTW+COUNT_W-1:0] count_ext;
    logic                wr_key_en;
    logic                wr_val_en;
    logic                wr_vld_en;
    logic                wr_vld_data;
    logic [IW-1:0]       wr_addr;

    // One slot read is issued per scan cycle until every slot is read.
    assign issue_en   = i_cmd.scan && (r_issue_cnt < CNTW'(CAPACITY));
    assign issue_addr = r_issue_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (issue_en) begin
            r_rd_key <= mem_key[issue_addr];
            r_rd_val <= mem_val[issue_addr];
            r_rd_vld <= mem_vld[issue_addr];
        end
    end

    // Slot writes: clearing pass or the write-back of a command.
    always_ff @(posedge i_clk) begin
        if (wr_vld_en) mem_vld[wr_addr] <= wr_vld_data;
        if (wr_key_en) mem_key[wr_addr] <= r_key;
        if (wr_val_en) mem_val[wr_addr] <= r_val;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd <= i_req_command;
            r_key <= i_req_key;
            r_val <= i_req_value;
        end
    end

    // Scan control: compare the registered slot against the key, note the
    // first match and the lowest free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_cnt <= '0;
            r_chk_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_chk_done  <= 1'b0;
        end else if (i_cmd.start) begin
            r_issue_cnt <= '0;
            r_chk_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_chk_done  <= 1'b0;
        end else begin
            r_chk_vld <= issue_en;
            if (issue_en) r_issue_cnt <= r_issue_cnt + CNTW'(1);
            if (r_chk_vld) begin
                if (r_rd_vld && (r_rd_key == r_key) && !r_hit) r_hit <= 1'b1;
                if (!r_rd_vld && !r_free) r_free <= 1'b1;
                if (r_chk_idx == IW'(CAPACITY - 1)) r_chk_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_en) r_chk_idx <= issue_addr;
        if (r_chk_vld && r_rd_vld && (r_rd_key == r_key) && !r_hit) begin
            r_hit_idx <= r_chk_idx;
            r_hit_val <= r_rd_val;
        end
        if (r_chk_vld && !r_rd_vld && !r_free) r_free_idx <= r_chk_idx;
    end

    // Clearing pass address after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + IW'(1);
        end
    end

    // Write-back decision and response contents.
    always_comb begin
        n_status    = ST_NOTFOUND;
        n_value     = '0;
        n_count     = r_count;
        wr_key_en   = 1'b0;
        wr_val_en   = 1'b0;
        wr_vld_en   = 1'b0;
        wr_vld_data = 1'b0;
        wr_addr     = r_hit_idx;
        priority if (i_cmd.clear) begin
            wr_vld_en = 1'b1;
            wr_addr   = r_clr_addr;
        end else if (i_cmd.finish) begin
            unique case (r_cmd)
                CMD_PUT: begin
                    if (r_hit) begin
                        wr_val_en = 1'b1;
                        n_status  = ST_UPDATED;
                    end else if (r_free) begin
                        wr_addr     = r_free_idx;
                        wr_key_en   = 1'b1;
                        wr_val_en   = 1'b1;
                        wr_vld_en   = 1'b1;
                        wr_vld_data = 1'b1;
                        n_count     = r_count + CNTW'(1);
                        n_status    = ST_INSERTED;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                CMD_FIND: begin
                    if (r_hit) begin
                        n_status = ST_FOUND;
                        n_value  = r_hit_val;
                    end
                end
                CMD_ERASE: begin
                    if (r_hit) begin
                        wr_vld_en   = 1'b1;
                        wr_vld_data = 1'b0;
                        if (r_count != '0) n_count = r_count - CNTW'(1);
                        n_status = ST_ERASED;
                    end
                end
                default: begin
                    n_status = ST_NOTFOUND;
                end
            endcase
        end else begin
            // Between commands nothing is written and the count holds.
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Response register: holds until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_count  <= count_ext[COUNT_W-1:0];
            r_out_empty  <= (n_count == '0);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_value;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;

    always_comb begin
        o_stat.clear_done = i_cmd.clear && (r_clr_addr == IW'(CAPACITY - 1));
        o_stat.scan_done  = r_hit || r_chk_done;
        o_stat.out_free   = !r_out_vld || i_out_ready;
    end

    // The count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("entry count above capacity");

    // A response is built only from a completed scan.
    a_finish_scanned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (r_hit || r_chk_done))
        else $error("write-back before the scan completed");

    // A put that finds neither its key nor a free slot means a full table.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_cmd == CMD_PUT) && !r_hit && !r_free)
            |-> (r_count == CNTW'(CAPACITY)))
        else $error("table reported full with slots free");

    // A successful erase lowers the count by one.
    a_erase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_cmd == CMD_ERASE) && r_hit)
            |=> (r_count == $past(r_count) - CNTW'(1)))
        else $error("erase did not decrement the count");

endmodule

`default_nettype wire

FILE: rtl/key_value_table.sv
// Bounded key/value table of signed 32-bit pairs, searched one slot per cycle.
// Requests arrive on i_req (command, lookup_key, new_value) and each produces
// exactly one response on o_rsp (status, found_value, entry_count, is_empty).
// Commands: put inserts into the lowest free slot or updates an existing key,
// find returns the stored value, erase frees the slot holding the key.
// The scan reads one slot per cycle from the key, value and valid memories
// with a registered read port, and stops early on a match.
// One request is in flight at a time; i_req.ready is high again from the cycle
// in which the response becomes valid, even if that response has not yet been
// taken; a new request is accepted only after the previous response is loaded.
// Reset clears the entry count and then runs a clearing pass over the valid
// bits, one slot per cycle; no request is accepted during that pass. When the
// receiver holds o_rsp.ready low, the response stays in its register and the
// next command waits before its write-back.
`default_nettype none

module key_value_table #(
    parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kvt_req_if.sink     i_req,
    kvt_rsp_if.source   o_rsp
);
    import kvt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer for clearing, scanning and write-back.
    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Slot memories, compare pipeline, count and response register.
    kvt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_req_command (i_req.command),
        .i_req_key     (i_req.lookup_key),
        .i_req_value   (i_req.new_value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_found_value (o_rsp.found_value),
        .o_entry_count (o_rsp.entry_count),
        .o_is_empty    (o_rsp.is_empty)
    );

endmodule

`default_nettype wire
